// ----- rtl/assert_macros.svh -----
// assertion macros shared by the interrupt controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define BMIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// expression must never be true outside reset
`define BMIC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// ----- rtl/bmic_pkg.sv -----
// types, constants and register map of the banked interrupt controller
package bmic_pkg;

    localparam int BANK_COUNT   = 4;
    localparam int BANK_W       = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int BANK_FIELD_W = 3;
    localparam int REG_FIELD_W  = 5;
    localparam int LINE_W       = 32;

    localparam logic [REG_FIELD_W-1:0] OFS_SOURCE   = 5'h00;
    localparam logic [REG_FIELD_W-1:0] OFS_MASK     = 5'h04;
    localparam logic [REG_FIELD_W-1:0] OFS_MASK_SET = 5'h08;
    localparam logic [REG_FIELD_W-1:0] OFS_MASK_CLR = 5'h0c;
    localparam logic [REG_FIELD_W-1:0] OFS_PENDING  = 5'h10;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LINE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_BANK = 2'd1,
        ST_BAD_REG  = 2'd2
    } status_t;

    typedef struct packed {
        logic [LINE_W-1:0] mask;
        logic [LINE_W-1:0] source;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t RESET_ENTRY = '{mask: '1, source: '0};

    // write-back of one bank entry
    typedef struct packed {
        logic              we;
        logic [BANK_W-1:0] idx;
        entry_t            entry;
    } wr_t;

endpackage

// ----- rtl/bmic_ram.sv -----
// generic single-write, single-read ram with registered read data
module bmic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bmic_pend.sv -----
// per-bank pending flags and the combined interrupt output
module bmic_pend (
    input  logic          aclk,
    input  logic          aresetn,
    input  bmic_pkg::wr_t wr,
    output logic          irq_next
);
    import bmic_pkg::*;

    `include "assert_macros.svh"

    logic [BANK_COUNT-1:0] flags_reg;
    logic [BANK_COUNT-1:0] flags_next;

    always_comb begin
        flags_next = flags_reg;
        if (wr.we) begin
            flags_next[wr.idx] = |(wr.entry.source & ~wr.entry.mask);
        end
    end

    assign irq_next = |flags_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    `BMIC_ASSERT(a_flag_tracks_write,
        wr.we |=> flags_reg[$past(wr.idx)] == $past(|(wr.entry.source & ~wr.entry.mask)),
        "pending flag does not match written entry")
    `BMIC_ASSERT(a_flags_hold,
        !wr.we |=> flags_reg == $past(flags_reg),
        "pending flags changed without a write")

endmodule

// ----- rtl/banked_masked_interrupt_controller.sv -----
// top level of the banked masked level-sensitive interrupt controller
//
// One transfer is taken per clock cycle while the result side does not stall, and each one
// gives exactly one result transfer through the s1 stage and output registers. Bank state
// (source and mask, 64 bits per bank) lives in one ram of BANK_COUNT entries: the entry is
// read at acceptance, modified in the s1 stage, written back as it leaves when updated, and
// the last write-back is forwarded to the next transfer when both address the same bank. A
// valid bit per entry makes a bank that was never written read as source all zeros, mask all
// ones, so there is no clearing pass after reset. irq_out comes from one pending flag per
// bank, kept next to the ram and updated on each write-back.
module banked_masked_interrupt_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[7:0], write_data[39:8], line_number[47:40], line_level[48], zeros above
    input  logic [55:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0], irq_out[32], status[34:33], zeros above
    output logic [39:0] m_tdata
);
    import bmic_pkg::*;

    `include "assert_macros.svh"

    logic [1:0]              in_op;
    logic [7:0]              in_addr;
    logic [LINE_W-1:0]       in_wdata;
    logic [7:0]              in_line;
    logic                    in_level;
    logic [BANK_FIELD_W-1:0] in_bank;
    logic                    s_fire;

    logic                    s1_valid_reg;
    logic [1:0]              s1_op_reg;
    logic [BANK_FIELD_W-1:0] s1_bank_reg;
    logic [REG_FIELD_W-1:0]  s1_ofs_reg;
    logic [LINE_W-1:0]       s1_wdata_reg;
    logic [4:0]              s1_bit_reg;
    logic                    s1_level_reg;
    logic                    s1_fire;

    logic                    wb_valid_reg;
    logic [BANK_W-1:0]       wb_idx_reg;
    entry_t                  wb_entry_reg;

    logic [BANK_COUNT-1:0]   valid_reg;

    logic [ENTRY_W-1:0]      ram_q;
    logic [BANK_W-1:0]       s1_idx;
    logic                    bank_ok;
    entry_t                  cur;
    entry_t                  nxt;
    logic                    upd;
    logic [LINE_W-1:0]       rdata;
    status_t                 status;
    logic [LINE_W-1:0]       bit_sel;
    wr_t                     wr;
    logic                    irq_next;

    logic                    m_valid_reg;
    logic [LINE_W-1:0]       m_rdata_reg;
    logic                    m_irq_reg;
    status_t                 m_status_reg;

    assign in_op    = s_tuser;
    assign in_addr  = s_tdata[7:0];
    assign in_wdata = s_tdata[39:8];
    assign in_line  = s_tdata[47:40];
    assign in_level = s_tdata[48];
    assign in_bank  = (in_op == OP_LINE) ? in_line[7:5] : in_addr[7:5];

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    bmic_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BANK_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr.we),
        .waddr (wr.idx),
        .wdata (wr.entry),
        .re    (s_fire),
        .raddr (in_bank[BANK_W-1:0]),
        .rdata (ram_q)
    );

    assign s1_idx  = s1_bank_reg[BANK_W-1:0];
    assign bank_ok = {1'b0, s1_bank_reg} < (BANK_FIELD_W + 1)'(BANK_COUNT);
    assign bit_sel = LINE_W'(1) << s1_bit_reg;

    always_comb begin
        cur = valid_reg[s1_idx] ? entry_t'(ram_q) : RESET_ENTRY;
        if (wb_valid_reg && wb_idx_reg == s1_idx) begin
            cur = wb_entry_reg;
        end
        nxt    = cur;
        upd    = 1'b0;
        rdata  = '0;
        status = ST_OK;
        case (s1_op_reg)
            OP_READ: begin
                if (!bank_ok) begin
                    status = ST_BAD_BANK;
                end else begin
                    case (s1_ofs_reg)
                        OFS_SOURCE:   rdata = cur.source;
                        OFS_MASK:     rdata = cur.mask;
                        OFS_MASK_SET: rdata = '0;
                        OFS_MASK_CLR: rdata = '0;
                        OFS_PENDING:  rdata = cur.source & ~cur.mask;
                        default:      status = ST_BAD_REG;
                    endcase
                end
            end
            OP_WRITE: begin
                if (!bank_ok) begin
                    status = ST_BAD_BANK;
                end else begin
                    case (s1_ofs_reg)
                        OFS_SOURCE:   upd = 1'b0;
                        OFS_PENDING:  upd = 1'b0;
                        OFS_MASK: begin
                            nxt.mask = s1_wdata_reg;
                            upd      = 1'b1;
                        end
                        OFS_MASK_SET: begin
                            nxt.mask = cur.mask | s1_wdata_reg;
                            upd      = 1'b1;
                        end
                        OFS_MASK_CLR: begin
                            nxt.mask = cur.mask & ~s1_wdata_reg;
                            upd      = 1'b1;
                        end
                        default:      status = ST_BAD_REG;
                    endcase
                end
            end
            OP_LINE: begin
                if (!bank_ok) begin
                    status = ST_BAD_BANK;
                end else begin
                    nxt.source = s1_level_reg ? (cur.source | bit_sel)
                                              : (cur.source & ~bit_sel);
                    upd        = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign wr.we    = s1_fire && upd;
    assign wr.idx   = s1_idx;
    assign wr.entry = nxt;

    bmic_pend u_pend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .irq_next (irq_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                wb_valid_reg <= upd;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
            if (wr.we) begin
                valid_reg[wr.idx] <= 1'b1;
            end
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_op_reg    <= in_op;
            s1_bank_reg  <= in_bank;
            s1_ofs_reg   <= in_addr[REG_FIELD_W-1:0];
            s1_wdata_reg <= in_wdata;
            s1_bit_reg   <= in_line[4:0];
            s1_level_reg <= in_level;
        end
        if (s1_fire) begin
            wb_idx_reg   <= s1_idx;
            wb_entry_reg <= nxt;
            m_rdata_reg  <= rdata;
            m_irq_reg    <= irq_next;
            m_status_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_status_reg, m_irq_reg, m_rdata_reg};

    `BMIC_ASSERT_NEVER(a_no_write_on_error,
        s1_valid_reg && status != ST_OK && upd,
        "state update on an errored transfer")
    `BMIC_ASSERT(a_error_reads_zero,
        m_valid_reg && m_status_reg != ST_OK |-> m_rdata_reg == '0,
        "non-zero read data with error status")
    `BMIC_ASSERT(a_writeback_forwarded,
        wr.we |=> wb_valid_reg && wb_idx_reg == $past(wr.idx),
        "write-back not held for forwarding")
    `BMIC_ASSERT(a_written_entry_valid,
        wr.we |=> valid_reg[$past(wr.idx)],
        "written bank left without valid bit")

endmodule

// ----- bench/bmic_checker.sv -----
// result checker for the banked interrupt controller: tracks bank state and compares replies
`timescale 1ns / 100ps

module bmic_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // address[7:0], write_data[39:8], line_number[47:40], line_level[48], zeros above
    input  logic [55:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0], irq_out[32], status[34:33], zeros above
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);
    import bmic_pkg::*;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_out;
        status_t     status;
    } reply_t;

    logic [LINE_W-1:0] source_word [BANK_COUNT];
    logic [LINE_W-1:0] mask_word   [BANK_COUNT];
    reply_t            pending_replies [$];

    // applies one input transfer to the bank state and returns the reply it should give
    function automatic reply_t apply_transfer(input logic [1:0] op, input logic [55:0] data);
        logic [7:0]        addr;
        logic [31:0]       wdata;
        logic [7:0]        line;
        logic              level;
        logic [2:0]        bank;
        logic [4:0]        ofs;
        logic [LINE_W-1:0] pend_acc;
        reply_t            r;
        addr        = data[7:0];
        wdata       = data[39:8];
        line        = data[47:40];
        level       = data[48];
        r.read_data = '0;
        r.status    = ST_OK;
        case (op)
            OP_READ, OP_WRITE: begin
                bank = addr[7:5];
                ofs  = addr[4:0];
                if (bank >= BANK_COUNT) begin
                    r.status = ST_BAD_BANK;
                end else if (op == OP_READ) begin
                    case (ofs)
                        OFS_SOURCE:                 r.read_data = source_word[bank];
                        OFS_MASK:                   r.read_data = mask_word[bank];
                        OFS_MASK_SET, OFS_MASK_CLR: r.read_data = '0;
                        OFS_PENDING: r.read_data = source_word[bank] & ~mask_word[bank];
                        default:                    r.status = ST_BAD_REG;
                    endcase
                end else begin
                    case (ofs)
                        OFS_SOURCE, OFS_PENDING: ;
                        OFS_MASK:     mask_word[bank] = wdata;
                        OFS_MASK_SET: mask_word[bank] = mask_word[bank] | wdata;
                        OFS_MASK_CLR: mask_word[bank] = mask_word[bank] & ~wdata;
                        default:      r.status = ST_BAD_REG;
                    endcase
                end
            end
            OP_LINE: begin
                bank = line[7:5];
                if (bank >= BANK_COUNT)
                    r.status = ST_BAD_BANK;
                else
                    source_word[bank][line[4:0]] = level;
            end
            default: ;
        endcase
        pend_acc = '0;
        for (int b = 0; b < BANK_COUNT; b++)
            pend_acc = pend_acc | (source_word[b] & ~mask_word[b]);
        r.irq_out = |pend_acc;
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t exp_r;
        if (!aresetn) begin
            for (int b = 0; b < BANK_COUNT; b++) begin
                source_word[b] = '0;
                mask_word[b]   = '1;
            end
            pending_replies.delete();
        end else begin
            if (s_tvalid && s_tready)
                pending_replies.push_back(apply_transfer(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    $error("result transfer with no reply expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_r = pending_replies.pop_front();
                    if (m_tdata[31:0] !== exp_r.read_data) begin
                        $error("read_data: expected %h, actual %h",
                               exp_r.read_data, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[32] !== exp_r.irq_out) begin
                        $error("irq_out: expected %b, actual %b", exp_r.irq_out, m_tdata[32]);
                        fail_count++;
                    end
                    if (m_tdata[34:33] !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_r.status, m_tdata[34:33]);
                        fail_count++;
                    end
                end
            end
        end
        outstanding <= pending_replies.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// top of the interrupt controller testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import bmic_pkg::*;

    localparam int         RANDOM_ITEMS = 1450;
    localparam int         CALM_FROM    = 1300;
    localparam int         LONG_HOLD    = 300;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam logic [1:0] OP_RESERVED  = 2'd3;
    localparam logic [4:0] OFS_ODD      = 5'h01;
    localparam logic [4:0] OFS_TOP      = 5'h1f;
    localparam logic [4:0] OFS_BEYOND   = 5'h14;
    localparam int         LAST_LINE    = BANK_COUNT * 32 - 1;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int fail_count;
    int outstanding;
    int items_done      = 0;
    int cycle_count     = 0;
    bit calm            = 1'b0;
    bit long_hold_done  = 1'b0;

    always #5 aclk = ~aclk;

    banked_masked_interrupt_controller u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bmic_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic logic [7:0] reg_addr(input int bank, input logic [4:0] ofs);
        return {3'(bank), ofs};
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_addr();
        logic [4:0] ofs;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       ofs = OFS_SOURCE;
            1:       ofs = OFS_MASK;
            2:       ofs = OFS_MASK_SET;
            3:       ofs = OFS_MASK_CLR;
            default: ofs = OFS_PENDING;
        endcase
        return reg_addr($urandom_range(0, BANK_COUNT - 1), ofs);
    endfunction

    function automatic logic [7:0] rand_line();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, LAST_LINE));
    endfunction

    // offers one transfer, then sometimes idles the input side for a burst
    task automatic offer(input logic [1:0] op, input logic [7:0] addr, input logic [31:0] wdata,
                         input logic [7:0] line, input logic level);
        s_tuser  <= op;
        s_tdata  <= {7'd0, level, line, wdata, addr};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_done++;
        if (!calm && ((items_done / 100) % 3 != 2) && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    task automatic offer_random();
        logic [1:0] op;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6:        op = OP_LINE;
            7, 8, 9, 10, 11, 12:        op = OP_READ;
            13, 14, 15, 16, 17, 18:     op = OP_WRITE;
            default:                    op = OP_RESERVED;
        endcase
        offer(op, rand_addr(), rand_word(), rand_line(), 1'($urandom_range(0, 1)));
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off, steady at the end
    initial begin
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (!long_hold_done && items_done >= 300) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, masked/out of range lines, unmasking, error cases
        offer(OP_READ,  reg_addr(0, OFS_SOURCE),   '0, '0, 1'b0);
        offer(OP_READ,  reg_addr(0, OFS_MASK),     '0, '0, 1'b0);
        offer(OP_READ,  reg_addr(0, OFS_PENDING),  '0, '0, 1'b0);
        offer(OP_LINE,  '0, '0, 8'd0, 1'b1);
        offer(OP_LINE,  '0, '1, 8'hff, 1'b1);
        offer(OP_LINE,  '0, '0, 8'(LAST_LINE), 1'b1);
        offer(OP_WRITE, reg_addr(0, OFS_MASK_CLR), 32'd1, '0, 1'b0);
        offer(OP_READ,  reg_addr(0, OFS_PENDING),  '0, '0, 1'b0);
        offer(OP_READ,  reg_addr(0, OFS_MASK_SET), '0, '0, 1'b0);
        offer(OP_READ,  reg_addr(0, OFS_MASK_CLR), '0, '0, 1'b0);
        offer(OP_WRITE, reg_addr(0, OFS_SOURCE),   '1, '0, 1'b0);
        offer(OP_WRITE, reg_addr(0, OFS_PENDING),  '1, '0, 1'b0);
        offer(OP_WRITE, reg_addr(0, OFS_MASK_SET), '1, '0, 1'b0);
        offer(OP_WRITE, reg_addr(BANK_COUNT - 1, OFS_MASK), '0, '0, 1'b0);
        offer(OP_READ,  reg_addr(BANK_COUNT - 1, OFS_PENDING), '0, '0, 1'b0);
        offer(OP_READ,  reg_addr(BANK_COUNT, OFS_SOURCE), '0, '0, 1'b0);
        offer(OP_READ,  8'hff, '1, '1, 1'b1);
        offer(OP_WRITE, reg_addr(7, OFS_MASK), '1, '0, 1'b0);
        offer(OP_READ,  reg_addr(0, OFS_ODD),    '0, '0, 1'b0);
        offer(OP_READ,  reg_addr(1, OFS_TOP),    '0, '0, 1'b0);
        offer(OP_READ,  reg_addr(2, OFS_BEYOND), '0, '0, 1'b0);
        offer(OP_WRITE, reg_addr(0, OFS_ODD | OFS_MASK), '0, '0, 1'b0);
        offer(OP_RESERVED, reg_addr(0, OFS_MASK), '0, 8'd0, 1'b1);
        offer(OP_LINE,  '0, '0, 8'(LAST_LINE), 1'b0);
        offer(OP_WRITE, reg_addr(BANK_COUNT - 1, OFS_MASK), '1, '0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= CALM_FROM)
                calm = 1'b1;
            offer_random();
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (outstanding != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- banked_masked_interrupt_controller.f -----
+incdir+rtl
rtl/bmic_pkg.sv
rtl/bmic_ram.sv
rtl/bmic_pend.sv
rtl/banked_masked_interrupt_controller.sv
bench/bmic_checker.sv
bench/tb_top.sv
